[sv/ces_pkg.sv]
`default_nettype none

package ces_pkg;

    // default geometry
    localparam int CHUNKS_DEF = 4;
    localparam int SPC_DEF    = 16;

    // field widths
    localparam int OP_W      = 2;
    localparam int IDX_W     = 8;
    localparam int WTYPE_W   = 3;
    localparam int TAG_W     = 3;
    localparam int VAL_W     = 64;
    localparam int ACT_W     = 3;
    localparam int SIZE_W    = 5;
    localparam int CNT_W     = 7;
    localparam int NUM_SIZES = 4;

    // configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // sequencer program counter
    localparam int UPC_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [TAG_W-1:0] {
        TAG_VOID   = 3'd0,
        TAG_INT    = 3'd1,
        TAG_FLOAT  = 3'd2,
        TAG_DOUBLE = 3'd3,
        TAG_CHAR   = 3'd4,
        TAG_SHORT  = 3'd5,
        TAG_BOOL   = 3'd6,
        TAG_ERROR  = 3'd7
    } t_tag;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_ACTIVE = 3'd0,
        REG_SIZE0  = 3'd1,
        REG_SIZE1  = 3'd2,
        REG_SIZE2  = 3'd3,
        REG_SIZE3  = 3'd4,
        REG_FILL   = 3'd5
    } t_reg_idx;

    // datapath micro-operations
    typedef enum logic [3:0] {
        U_NOP,
        U_ACCEPT,
        U_INIT_LATCH,
        U_INIT_PREP,
        U_INIT_SLOT,
        U_CHECK,
        U_WALK,
        U_READ_RES,
        U_WRITE,
        U_EMIT
    } t_uop;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEXT,
        C_GOTO,
        C_DISPATCH,
        C_SLOT_LOOP,
        C_RANGE,
        C_WALK,
        C_IS_WRITE,
        C_OUT
    } t_cond;

    typedef struct packed {
        t_uop             uop;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic    accepted;
        t_opcode in_op;
        t_opcode item_op;
        logic    range_bad;
        logic    walk_hit;
        logic    walk_fail;
        logic    slot_last;
        logic    out_free;
    } t_status;

    typedef struct packed {
        logic [ACT_W-1:0]                  active;
        logic [NUM_SIZES-1:0][SIZE_W-1:0]  size;
        logic [CNT_W-1:0]                  fill;
    } t_cfg;

    // program addresses
    localparam logic [UPC_W-1:0] UPC_IDLE       = 4'd0;
    localparam logic [UPC_W-1:0] UPC_INIT_LATCH = 4'd1;
    localparam logic [UPC_W-1:0] UPC_INIT_PREP  = 4'd2;
    localparam logic [UPC_W-1:0] UPC_INIT_SLOT  = 4'd3;
    localparam logic [UPC_W-1:0] UPC_EMIT       = 4'd4;
    localparam logic [UPC_W-1:0] UPC_CHECK      = 4'd5;
    localparam logic [UPC_W-1:0] UPC_WALK       = 4'd6;
    localparam logic [UPC_W-1:0] UPC_SETTLE     = 4'd7;
    localparam logic [UPC_W-1:0] UPC_READ_RES   = 4'd8;
    localparam logic [UPC_W-1:0] UPC_WRITE      = 4'd9;

    // microcode rom
    function automatic t_ctrl ces_ucode(input logic [UPC_W-1:0] upc);
        t_ctrl w;
        w = '{uop: U_NOP, cond: C_GOTO, target: UPC_IDLE};
        case (upc)
            UPC_IDLE:       w = '{uop: U_ACCEPT,     cond: C_DISPATCH,  target: UPC_IDLE};
            UPC_INIT_LATCH: w = '{uop: U_INIT_LATCH, cond: C_NEXT,      target: UPC_IDLE};
            UPC_INIT_PREP:  w = '{uop: U_INIT_PREP,  cond: C_NEXT,      target: UPC_IDLE};
            UPC_INIT_SLOT:  w = '{uop: U_INIT_SLOT,  cond: C_SLOT_LOOP, target: UPC_INIT_SLOT};
            UPC_EMIT:       w = '{uop: U_EMIT,       cond: C_OUT,       target: UPC_IDLE};
            UPC_CHECK:      w = '{uop: U_CHECK,      cond: C_RANGE,     target: UPC_EMIT};
            UPC_WALK:       w = '{uop: U_WALK,       cond: C_WALK,      target: UPC_EMIT};
            UPC_SETTLE:     w = '{uop: U_NOP,        cond: C_IS_WRITE,  target: UPC_WRITE};
            UPC_READ_RES:   w = '{uop: U_READ_RES,   cond: C_GOTO,      target: UPC_EMIT};
            UPC_WRITE:      w = '{uop: U_WRITE,      cond: C_GOTO,      target: UPC_EMIT};
            default:        w = '{uop: U_NOP,        cond: C_GOTO,      target: UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[sv/ces_store.sv]
`default_nettype none

module ces_store #(
    parameter int DEPTH = ces_pkg::CHUNKS_DEF * ces_pkg::SPC_DEF,
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [SLOT_W-1:0]         i_wr_addr,
    input  logic [ces_pkg::TAG_W-1:0] i_wr_tag,
    input  logic [ces_pkg::VAL_W-1:0] i_wr_pay,
    input  logic [SLOT_W-1:0]         i_rd_addr,
    output logic [ces_pkg::TAG_W-1:0] o_rd_tag,
    output logic [ces_pkg::VAL_W-1:0] o_rd_pay
);
    import ces_pkg::*;

    logic [TAG_W-1:0] r_tag_mem [DEPTH];
    logic [VAL_W-1:0] r_pay_mem [DEPTH];

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tag_mem[i_wr_addr] <= i_wr_tag;
            r_pay_mem[i_wr_addr] <= i_wr_pay;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_tag <= r_tag_mem[i_rd_addr];
        o_rd_pay <= r_pay_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[sv/ces_seq.sv]
`default_nettype none

module ces_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ces_pkg::t_status i_status,
    output ces_pkg::t_uop    o_uop
);
    import ces_pkg::*;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_ctrl            ctrl;

    // control word of the current step
    assign ctrl  = ces_ucode(r_upc);
    assign o_uop = ctrl.uop;

    // step counter with conditional jumps
    always_comb begin
        n_upc = r_upc;
        case (ctrl.cond)
            C_NEXT: begin
                n_upc = r_upc + UPC_W'(1);
            end
            C_GOTO: begin
                n_upc = ctrl.target;
            end
            C_DISPATCH: begin
                if (i_status.accepted) begin
                    case (i_status.in_op)
                        OP_INIT:  n_upc = UPC_INIT_LATCH;
                        OP_READ:  n_upc = UPC_CHECK;
                        OP_WRITE: n_upc = UPC_CHECK;
                        default:  n_upc = UPC_EMIT;
                    endcase
                end
            end
            C_SLOT_LOOP: begin
                n_upc = i_status.slot_last ? r_upc + UPC_W'(1) : ctrl.target;
            end
            C_RANGE: begin
                n_upc = i_status.range_bad ? ctrl.target : r_upc + UPC_W'(1);
            end
            C_WALK: begin
                if (i_status.walk_hit) begin
                    n_upc = r_upc + UPC_W'(1);
                end else if (i_status.walk_fail) begin
                    n_upc = ctrl.target;
                end
            end
            C_IS_WRITE: begin
                n_upc = (i_status.item_op == OP_WRITE) ? ctrl.target : r_upc + UPC_W'(1);
            end
            C_OUT: begin
                if (i_status.out_free) begin
                    n_upc = ctrl.target;
                end
            end
            default: begin
                n_upc = UPC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

`default_nettype wire

[sv/ces_dp.sv]
`default_nettype none

module ces_dp #(
    parameter int CHUNKS          = ces_pkg::CHUNKS_DEF,
    parameter int SLOTS_PER_CHUNK = ces_pkg::SPC_DEF,
    localparam int DEPTH  = CHUNKS * SLOTS_PER_CHUNK,
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ces_pkg::t_uop                      i_uop,
    output ces_pkg::t_status                   o_status,
    input  ces_pkg::t_cfg                      i_cfg,
    input  logic                               i_in_valid,
    input  logic [ces_pkg::OP_W-1:0]           i_opcode,
    input  logic signed [ces_pkg::IDX_W-1:0]   i_index,
    input  logic [ces_pkg::WTYPE_W-1:0]        i_write_type,
    input  logic [ces_pkg::VAL_W-1:0]          i_payload,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic                               o_ok,
    output logic [ces_pkg::TAG_W-1:0]          o_elem_type,
    output logic [ces_pkg::VAL_W-1:0]          o_elem_value,
    output logic                               o_wr_en,
    output logic [SLOT_W-1:0]                  o_wr_addr,
    output logic [ces_pkg::TAG_W-1:0]          o_wr_tag,
    output logic [ces_pkg::VAL_W-1:0]          o_wr_pay,
    output logic [SLOT_W-1:0]                  o_rd_addr,
    input  logic [ces_pkg::TAG_W-1:0]          i_rd_tag,
    input  logic [ces_pkg::VAL_W-1:0]          i_rd_pay
);
    import ces_pkg::*;

    localparam int CH_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int K_W  = (SLOTS_PER_CHUNK > 1) ? $clog2(SLOTS_PER_CHUNK) : 1;

    // latched request
    t_opcode              r_op,      n_op;
    logic [IDX_W-1:0]     r_index,   n_index;
    logic [WTYPE_W-1:0]   r_wtype,   n_wtype;
    logic [VAL_W-1:0]     r_payload, n_payload;

    // pending result
    logic                 r_res_ok,   n_res_ok;
    t_tag                 r_res_type, n_res_type;
    logic [VAL_W-1:0]     r_res_val,  n_res_val;

    // geometry latched at init
    logic [ACT_W-1:0]     r_live_chunks, n_live_chunks;
    logic [SIZE_W-1:0]    r_live_size [CHUNKS];
    logic [SIZE_W-1:0]    n_live_size [CHUNKS];
    logic [CNT_W-1:0]     r_total, n_total;
    logic [CNT_W-1:0]     r_fill,  n_fill;
    logic [CNT_W-1:0]     r_next,  n_next;

    // walk and sweep counters
    logic [CH_W-1:0]      r_chunk, n_chunk;
    logic [K_W-1:0]       r_k,     n_k;
    logic [SLOT_W-1:0]    r_slot,  n_slot;
    logic [CNT_W-1:0]     r_rem,   n_rem;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_ok,    n_out_ok;
    t_tag                 r_out_type,  n_out_type;
    logic [VAL_W-1:0]     r_out_val,   n_out_val;

    logic                 accepted;
    logic                 range_bad;
    logic                 walk_hit;
    logic                 walk_fail;
    logic                 slot_last;
    logic                 out_free;
    logic                 usable;
    logic                 wtype_ok;
    t_tag                 rd_tag;
    logic [ACT_W-1:0]     act_clamped;
    logic [SIZE_W-1:0]    size_clamped [CHUNKS];
    logic [CNT_W-1:0]     size_sum;

    assign rd_tag = t_tag'(i_rd_tag);

    // status toward the sequencer
    assign accepted  = (i_uop == U_ACCEPT) && i_in_valid;
    assign range_bad = r_index[IDX_W-1] || (r_index[CNT_W-1:0] >= r_total);
    assign walk_hit  = (int'(r_chunk) < int'(r_live_chunks))
                       && (int'(r_rem) < int'(r_live_size[r_chunk]));
    assign walk_fail = !walk_hit && (int'(r_chunk) == CHUNKS - 1);
    assign slot_last = (int'(r_slot) == DEPTH - 1);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign usable    = int'(r_k) < int'(r_live_size[r_chunk]);
    assign wtype_ok  = r_wtype inside {[3'd1:3'd6]};

    assign o_status = '{
        accepted:  accepted,
        in_op:     t_opcode'(i_opcode),
        item_op:   r_op,
        range_bad: range_bad,
        walk_hit:  walk_hit,
        walk_fail: walk_fail,
        slot_last: slot_last,
        out_free:  out_free
    };

    // clamped geometry from the configuration registers
    always_comb begin
        act_clamped = (int'(i_cfg.active) > CHUNKS) ? ACT_W'(CHUNKS) : i_cfg.active;
        size_sum    = '0;
        for (int c = 0; c < CHUNKS; c++) begin
            size_clamped[c] = '0;
            if (c < int'(act_clamped)) begin
                if (int'(i_cfg.size[c]) > SLOTS_PER_CHUNK) begin
                    size_clamped[c] = SIZE_W'(SLOTS_PER_CHUNK);
                end else begin
                    size_clamped[c] = i_cfg.size[c];
                end
            end
            size_sum = size_sum + CNT_W'(size_clamped[c]);
        end
    end

    // datapath actions for each micro-operation
    always_comb begin
        n_op          = r_op;
        n_index       = r_index;
        n_wtype       = r_wtype;
        n_payload     = r_payload;
        n_res_ok      = r_res_ok;
        n_res_type    = r_res_type;
        n_res_val     = r_res_val;
        n_live_chunks = r_live_chunks;
        n_live_size   = r_live_size;
        n_total       = r_total;
        n_fill        = r_fill;
        n_next        = r_next;
        n_chunk       = r_chunk;
        n_k           = r_k;
        n_slot        = r_slot;
        n_rem         = r_rem;
        n_out_valid   = r_out_valid;
        n_out_ok      = r_out_ok;
        n_out_type    = r_out_type;
        n_out_val     = r_out_val;
        o_wr_en       = 1'b0;
        o_wr_addr     = r_slot;
        o_wr_tag      = TAG_W'(TAG_VOID);
        o_wr_pay      = '0;

        // drain the output register
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (i_uop)
            U_ACCEPT: begin
                if (i_in_valid) begin
                    n_op       = t_opcode'(i_opcode);
                    n_index    = i_index;
                    n_wtype    = i_write_type;
                    n_payload  = i_payload;
                    n_res_ok   = 1'b0;
                    n_res_type = (t_opcode'(i_opcode) == OP_READ) ? TAG_ERROR : TAG_VOID;
                    n_res_val  = '0;
                end
            end
            U_INIT_LATCH: begin
                n_live_chunks = act_clamped;
                n_live_size   = size_clamped;
                n_total       = size_sum;
            end
            U_INIT_PREP: begin
                n_fill   = (i_cfg.fill > r_total) ? r_total : i_cfg.fill;
                n_next   = '0;
                n_slot   = '0;
                n_chunk  = '0;
                n_k      = '0;
                n_res_ok = 1'b1;
            end
            U_INIT_SLOT: begin
                // one slot per step in flat order
                o_wr_en = 1'b1;
                if (usable && (r_next < r_fill)) begin
                    o_wr_tag = TAG_W'(TAG_INT);
                    o_wr_pay = VAL_W'(r_next);
                    n_next   = r_next + CNT_W'(1);
                end else if (usable) begin
                    o_wr_tag = TAG_W'(TAG_VOID);
                end else begin
                    o_wr_tag = TAG_W'(TAG_ERROR);
                end
                if (!slot_last) begin
                    n_slot = r_slot + SLOT_W'(1);
                    if (int'(r_k) == SLOTS_PER_CHUNK - 1) begin
                        n_k     = '0;
                        n_chunk = r_chunk + CH_W'(1);
                    end else begin
                        n_k = r_k + K_W'(1);
                    end
                end
            end
            U_CHECK: begin
                n_rem   = r_index[CNT_W-1:0];
                n_chunk = '0;
            end
            U_WALK: begin
                // subtract chunk sizes until the index lands
                if (walk_hit) begin
                    n_slot = SLOT_W'(int'(r_chunk) * SLOTS_PER_CHUNK + int'(r_rem));
                end else if (!walk_fail) begin
                    n_rem   = r_rem - CNT_W'(r_live_size[r_chunk]);
                    n_chunk = r_chunk + CH_W'(1);
                end
            end
            U_READ_RES: begin
                if (rd_tag != TAG_ERROR) begin
                    n_res_ok   = 1'b1;
                    n_res_type = rd_tag;
                    n_res_val  = i_rd_pay;
                end
            end
            U_WRITE: begin
                if (wtype_ok && (rd_tag != TAG_ERROR)) begin
                    o_wr_en  = 1'b1;
                    o_wr_tag = r_wtype;
                    o_wr_pay = r_payload;
                    n_res_ok = 1'b1;
                end
            end
            U_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_type  = r_res_type;
                    n_out_val   = r_res_val;
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live_chunks <= '0;
            r_total       <= '0;
            r_fill        <= '0;
            r_next        <= '0;
            r_chunk       <= '0;
            r_k           <= '0;
            r_slot        <= '0;
            r_out_valid   <= 1'b0;
            for (int c = 0; c < CHUNKS; c++) begin
                r_live_size[c] <= '0;
            end
        end else begin
            r_live_chunks <= n_live_chunks;
            r_live_size   <= n_live_size;
            r_total       <= n_total;
            r_fill        <= n_fill;
            r_next        <= n_next;
            r_chunk       <= n_chunk;
            r_k           <= n_k;
            r_slot        <= n_slot;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_index    <= n_index;
        r_wtype    <= n_wtype;
        r_payload  <= n_payload;
        r_res_ok   <= n_res_ok;
        r_res_type <= n_res_type;
        r_res_val  <= n_res_val;
        r_rem      <= n_rem;
        r_out_ok   <= n_out_ok;
        r_out_type <= n_out_type;
        r_out_val  <= n_out_val;
    end

    assign o_rd_addr    = r_slot;
    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_out_ok;
    assign o_elem_type  = TAG_W'(r_out_type);
    assign o_elem_value = r_out_val;

`ifndef SYNTH
    // the fill sweep never hands out more index values than the clamped fill
    a_next_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= r_fill)
        else $error("fill counter ran past fill limit");

    // an accepted access never reports success on an error tag
    a_ok_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_ok && (o_elem_type == TAG_W'(TAG_ERROR))))
        else $error("ok result carries error tag");

    // an init that is emitted shows up as a successful result
    a_init_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uop == U_EMIT && out_free && r_op == OP_INIT) |=> (o_out_valid && o_ok))
        else $error("init result not reported as ok");

    // latched chunk count stays within the built chunks
    a_live_chunks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_live_chunks) <= CHUNKS)
        else $error("live chunk count out of range");
`endif

endmodule

`default_nettype wire

[sv/chunked_typed_element_store.sv]
// Chunked store of typed elements, driven by a small microcoded sequencer.
// Request channel: i_in_valid / o_in_stall with i_opcode (init, read, write),
// i_index, i_write_type and i_payload; a request is taken at an edge with
// valid high and stall low. Result channel: o_out_valid / i_out_stall with
// o_ok, o_elem_type and o_elem_value, one result per request.
// The APB port sets chunk count, chunk sizes and initial fill; these take
// effect at the next init request.
// One request in flight at a time, in these steps:
//   read/write: accept, range check, a walk over w chunk sizes, where w
//     (1..CHUNKS) is the number walked, a settle step for the registered
//     memory read, the read result or the write, and the emit. An index
//     out of range goes from the check to the emit, the unused opcode
//     from the accept to the emit.
//   init: latch, prepare, one memory write per slot through the single write
//     port, one slot per cycle over CHUNKS*SLOTS_PER_CHUNK slots; then emit.
// Reset clears the control and configuration registers and the latched
// geometry; the store then holds no usable slot until an init request.
// While the receiver stalls, the result waits in the output register; one
// more request can be taken, and its result then holds the sequencer
// until the output register frees up.
`default_nettype none

module chunked_typed_element_store #(
    parameter int CHUNKS          = ces_pkg::CHUNKS_DEF,
    parameter int SLOTS_PER_CHUNK = ces_pkg::SPC_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [ces_pkg::OP_W-1:0]           i_opcode,
    input  logic signed [ces_pkg::IDX_W-1:0]   i_index,
    input  logic [ces_pkg::WTYPE_W-1:0]        i_write_type,
    input  logic [ces_pkg::VAL_W-1:0]          i_payload,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_ok,
    output logic [ces_pkg::TAG_W-1:0]          o_elem_type,
    output logic [ces_pkg::VAL_W-1:0]          o_elem_value,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ces_pkg::PADDR_W-1:0]        paddr,
    input  logic [ces_pkg::PDATA_W-1:0]        pwdata,
    output logic [ces_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import ces_pkg::*;

    localparam int DEPTH  = CHUNKS * SLOTS_PER_CHUNK;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cfg               r_cfg;
    t_reg_idx           reg_sel;
    logic               cfg_wr;
    t_uop               uop;
    t_status            status;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [TAG_W-1:0]   wr_tag;
    logic [VAL_W-1:0]   wr_pay;
    logic [SLOT_W-1:0]  rd_addr;
    logic [TAG_W-1:0]   rd_tag;
    logic [VAL_W-1:0]   rd_pay;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_ACTIVE: r_cfg.active  <= pwdata[ACT_W-1:0];
                REG_SIZE0:  r_cfg.size[0] <= pwdata[SIZE_W-1:0];
                REG_SIZE1:  r_cfg.size[1] <= pwdata[SIZE_W-1:0];
                REG_SIZE2:  r_cfg.size[2] <= pwdata[SIZE_W-1:0];
                REG_SIZE3:  r_cfg.size[3] <= pwdata[SIZE_W-1:0];
                REG_FILL:   r_cfg.fill    <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_sel)
            REG_ACTIVE: prdata = PDATA_W'(r_cfg.active);
            REG_SIZE0:  prdata = PDATA_W'(r_cfg.size[0]);
            REG_SIZE1:  prdata = PDATA_W'(r_cfg.size[1]);
            REG_SIZE2:  prdata = PDATA_W'(r_cfg.size[2]);
            REG_SIZE3:  prdata = PDATA_W'(r_cfg.size[3]);
            REG_FILL:   prdata = PDATA_W'(r_cfg.fill);
            default:    prdata = '0;
        endcase
    end

    // requests are taken only in the idle step of the program
    assign o_in_stall = (uop != U_ACCEPT);

    ces_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_uop    (uop)
    );

    ces_dp #(
        .CHUNKS          (CHUNKS),
        .SLOTS_PER_CHUNK (SLOTS_PER_CHUNK)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_uop        (uop),
        .o_status     (status),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .i_opcode     (i_opcode),
        .i_index      (i_index),
        .i_write_type (i_write_type),
        .i_payload    (i_payload),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_ok         (o_ok),
        .o_elem_type  (o_elem_type),
        .o_elem_value (o_elem_value),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_tag     (wr_tag),
        .o_wr_pay     (wr_pay),
        .o_rd_addr    (rd_addr),
        .i_rd_tag     (rd_tag),
        .i_rd_pay     (rd_pay)
    );

    ces_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_tag  (wr_tag),
        .i_wr_pay  (wr_pay),
        .i_rd_addr (rd_addr),
        .o_rd_tag  (rd_tag),
        .o_rd_pay  (rd_pay)
    );

endmodule

`default_nettype wire

[tb/chunked_typed_element_store_test.sv]
`timescale 1ns / 100ps

module chunked_typed_element_store_test;
    import ces_pkg::*;

    localparam int NCHUNK          = CHUNKS_DEF;
    localparam int NSLOT           = SPC_DEF;
    localparam int STORE_DEPTH     = NCHUNK * NSLOT;
    localparam int PHASES          = 10;
    localparam int REQS_PER_PHASE  = 38;
    localparam int HOLD_CYCLES     = 300;
    localparam int QUIET_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 80;

    typedef struct packed {
        t_opcode              op;
        logic [IDX_W-1:0]     idx;
        logic [WTYPE_W-1:0]   wtype;
        logic [VAL_W-1:0]     data;
    } store_req_t;

    typedef struct packed {
        logic             ok;
        t_tag             tag;
        logic [VAL_W-1:0] value;
    } elem_result_t;

    typedef enum logic {
        ROW_REQ,
        ROW_REG
    } row_kind_t;

    typedef struct {
        row_kind_t    kind;
        bit           typed;
        store_req_t   rq;
        elem_result_t res;
        t_reg_idx     ridx;
        logic [31:0]  rval;
    } stim_row_t;

    // clock, reset and block inputs
    logic                 i_clk     = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic [OP_W-1:0]      req_op    = '0;
    logic [IDX_W-1:0]     req_idx   = '0;
    logic [WTYPE_W-1:0]   req_wtype = '0;
    logic [VAL_W-1:0]     req_data  = '0;
    logic                 res_stall = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [PDATA_W-1:0]   pwdata    = '0;

    // block outputs
    logic                 req_stall;
    logic                 res_valid;
    logic                 res_ok;
    logic [TAG_W-1:0]     res_type;
    logic [VAL_W-1:0]     res_value;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // shadow of the store
    t_tag                 slot_tag [STORE_DEPTH];
    logic [VAL_W-1:0]     slot_val [STORE_DEPTH];
    int                   elem_total;
    int                   geo_chunks;
    int                   geo_size [NCHUNK];
    int                   cfg_active;
    int                   cfg_size [NUM_SIZES];
    int                   cfg_fill;

    elem_result_t         pending_results [$];
    stim_row_t            directed_rows [$];

    int  mismatch_count;
    int  req_count;
    int  result_count;
    int  reg_writes;
    int  init_count;
    bit  calm;
    bit  hold_now;

    chunked_typed_element_store dut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .o_in_stall   (req_stall),
        .i_opcode     (req_op),
        .i_index      (req_idx),
        .i_write_type (req_wtype),
        .i_payload    (req_data),
        .o_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .o_ok         (res_ok),
        .o_elem_type  (res_type),
        .o_elem_value (res_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // map a flat index onto a slot through the latched chunk sizes
    function automatic bit find_slot(input logic [IDX_W-1:0] idx, output int slot);
        int rem;
        slot = 0;
        if (idx[IDX_W-1] || int'(idx) >= elem_total) return 1'b0;
        rem = int'(idx);
        for (int c = 0; c < geo_chunks; c++) begin
            if (rem < geo_size[c]) begin
                slot = c * NSLOT + rem;
                return 1'b1;
            end
            rem -= geo_size[c];
        end
        return 1'b0;
    endfunction

    // latch geometry, then lay out int / void / error slots
    function automatic void rebuild_store();
        int fill;
        int nxt;
        int s;
        geo_chunks = (cfg_active > NCHUNK) ? NCHUNK : cfg_active;
        elem_total = 0;
        for (int c = 0; c < NCHUNK; c++) begin
            geo_size[c] = 0;
            if (c < geo_chunks) geo_size[c] = (cfg_size[c] > NSLOT) ? NSLOT : cfg_size[c];
            elem_total += geo_size[c];
        end
        fill = (cfg_fill > elem_total) ? elem_total : cfg_fill;
        nxt = 0;
        for (int c = 0; c < NCHUNK; c++) begin
            for (int k = 0; k < NSLOT; k++) begin
                s = c * NSLOT + k;
                slot_val[s] = '0;
                if (k >= geo_size[c]) begin
                    slot_tag[s] = TAG_ERROR;
                end else if (nxt < fill) begin
                    slot_tag[s] = TAG_INT;
                    slot_val[s] = VAL_W'(nxt);
                    nxt++;
                end else begin
                    slot_tag[s] = TAG_VOID;
                end
            end
        end
    endfunction

    // advance the shadow store by one request and return its result
    function automatic elem_result_t apply_request(input store_req_t rq);
        elem_result_t r;
        int slot;
        bit hit;
        r = '{ok: 1'b0, tag: TAG_VOID, value: '0};
        hit = find_slot(rq.idx, slot);
        case (rq.op)
            OP_INIT: begin
                rebuild_store();
                r.ok = 1'b1;
                init_count++;
            end
            OP_READ: begin
                if (hit && slot_tag[slot] != TAG_ERROR) begin
                    r.ok = 1'b1;
                    r.tag = slot_tag[slot];
                    r.value = slot_val[slot];
                end else begin
                    r.tag = TAG_ERROR;
                end
            end
            OP_WRITE: begin
                if (rq.wtype >= TAG_INT && rq.wtype <= TAG_BOOL && hit
                    && slot_tag[slot] != TAG_ERROR) begin
                    slot_tag[slot] = t_tag'(rq.wtype);
                    slot_val[slot] = rq.data;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic store_req_t random_request();
        store_req_t rq;
        int pick;
        pick = $urandom_range(0, 99);
        rq.data = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0) rq.data = ($urandom_range(0, 1) != 0) ? '1 : '0;
        if ($urandom_range(0, 9) == 0) rq.wtype = WTYPE_W'($urandom);
        else rq.wtype = WTYPE_W'($urandom_range(TAG_INT, TAG_BOOL));
        if (elem_total > 0 && $urandom_range(0, 99) < 85)
            rq.idx = IDX_W'($urandom_range(0, elem_total - 1));
        else
            rq.idx = IDX_W'($urandom);
        if (pick < 3) rq.op = OP_INIT;
        else if (pick < 6) rq.op = OP_NONE;
        else if (pick < 52) rq.op = OP_READ;
        else rq.op = OP_WRITE;
        return rq;
    endfunction

    // directed table builders
    function automatic void add_req(t_opcode op, int idx, int wt, logic [VAL_W-1:0] data);
        stim_row_t row;
        row.kind = ROW_REQ;
        row.typed = 1'b0;
        row.rq = '{op: op, idx: IDX_W'(idx), wtype: WTYPE_W'(wt), data: data};
        row.res = '0;
        row.ridx = REG_ACTIVE;
        row.rval = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_fixed(t_opcode op, int idx, int wt, logic [VAL_W-1:0] data,
                                      logic ok, t_tag tag, logic [VAL_W-1:0] value);
        add_req(op, idx, wt, data);
        directed_rows[$].typed = 1'b1;
        directed_rows[$].res = '{ok: ok, tag: tag, value: value};
    endfunction

    function automatic void add_reg(t_reg_idx ridx, logic [31:0] v);
        stim_row_t row;
        row.kind = ROW_REG;
        row.typed = 1'b0;
        row.rq = '0;
        row.res = '0;
        row.ridx = ridx;
        row.rval = v;
        directed_rows.push_back(row);
    endfunction

    // one apb transfer, setup then access, then idle
    task automatic cfg_access(input bit wr, input t_reg_idx ridx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= PADDR_W'({ridx, 2'b00});
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // write a register, mirror it, read it back
    task automatic set_register(input t_reg_idx ridx, input logic [31:0] v);
        logic [31:0] rd;
        cfg_access(1'b1, ridx, v, rd);
        reg_writes++;
        case (ridx)
            REG_ACTIVE: cfg_active = int'(v);
            REG_FILL:   cfg_fill = int'(v);
            default:    cfg_size[int'(ridx) - int'(REG_SIZE0)] = int'(v);
        endcase
        cfg_access(1'b0, ridx, '0, rd);
        if (rd !== v) begin
            $error("register %s readback: expected %0d, got %0d", ridx.name(), v, rd);
            mismatch_count++;
        end
    endtask

    // stop offering, let every result come back, let the sequencer settle
    task automatic drain_requests();
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_geometry(input int act, input int s0, input int s1, input int s2,
                                 input int s3, input int fill);
        drain_requests();
        set_register(REG_ACTIVE, act);
        set_register(REG_SIZE0, s0);
        set_register(REG_SIZE1, s1);
        set_register(REG_SIZE2, s2);
        set_register(REG_SIZE3, s3);
        set_register(REG_FILL, fill);
    endtask

    // offer one request and hold it until taken
    task automatic send_request(input store_req_t rq, input bit typed,
                                input elem_result_t typed_res);
        elem_result_t r;
        if (!calm && $urandom_range(0, 99) < 20) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_op <= rq.op;
        req_idx <= rq.idx;
        req_wtype <= rq.wtype;
        req_data <= rq.data;
        do @(posedge i_clk); while (req_stall);
        r = apply_request(rq);
        pending_results.push_back(typed ? typed_res : r);
        req_count++;
    endtask

    // result side: check against the oldest expectation, stall at random
    initial begin : result_sink
        elem_result_t want;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (res_valid && !res_stall) begin
                result_count++;
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (res_ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, res_ok);
                        mismatch_count++;
                    end
                    if (res_type !== want.tag) begin
                        $error("elem_type: expected %0d, got %0d", want.tag, res_type);
                        mismatch_count++;
                    end
                    if (res_value !== want.value) begin
                        $error("elem_value: expected %h, got %h", want.value, res_value);
                        mismatch_count++;
                    end
                end
            end
            if (hold_now) begin
                // long hold-off so the block backs up into the request side
                hold_now = 1'b0;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                res_stall <= 1'b0;
            end else begin
                res_stall <= !calm && ($urandom_range(0, 99) < 6);
            end
        end
    end

    // end the run if nothing moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_valid && !req_stall) || (res_valid && !res_stall)) quiet = 0;
            else quiet++;
        end
        $error("no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("FAIL chunked_typed_element_store");
        $finish;
    end

    initial begin : stimulus
        int directed_count;
        mismatch_count = 0;
        req_count = 0;
        result_count = 0;
        reg_writes = 0;
        init_count = 0;
        calm = 1'b0;
        hold_now = 1'b0;
        elem_total = 0;
        geo_chunks = 0;
        cfg_active = 0;
        cfg_fill = 0;
        foreach (geo_size[c]) geo_size[c] = 0;
        foreach (cfg_size[c]) cfg_size[c] = 0;
        foreach (slot_tag[s]) begin
            slot_tag[s] = TAG_ERROR;
            slot_val[s] = '0;
        end

        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing usable after reset
        add_fixed(OP_READ, 0, 0, '0, 1'b0, TAG_ERROR, '0);
        add_fixed(OP_WRITE, 0, TAG_INT, 64'h1234, 1'b0, TAG_VOID, '0);
        add_fixed(OP_NONE, -1, 7, '1, 1'b0, TAG_VOID, '0);
        add_fixed(OP_INIT, 0, 0, '0, 1'b1, TAG_VOID, '0);
        add_fixed(OP_READ, 0, 0, '0, 1'b0, TAG_ERROR, '0);
        // registers above their clamps, empty chunk between used ones
        add_reg(REG_ACTIVE, 7);
        add_reg(REG_SIZE0, 31);
        add_reg(REG_SIZE1, 16);
        add_reg(REG_SIZE2, 0);
        add_reg(REG_SIZE3, 5);
        add_reg(REG_FILL, 127);
        add_fixed(OP_INIT, 0, 0, '0, 1'b1, TAG_VOID, '0);
        add_req(OP_READ, 0, 0, '0);
        add_req(OP_READ, 16, 0, '0);
        add_req(OP_READ, 36, 0, '0);
        // out of range and negative indexes
        add_fixed(OP_READ, 37, 0, '0, 1'b0, TAG_ERROR, '0);
        add_fixed(OP_READ, -128, 0, '0, 1'b0, TAG_ERROR, '0);
        add_fixed(OP_READ, 127, 0, '0, 1'b0, TAG_ERROR, '0);
        add_fixed(OP_WRITE, -1, TAG_INT, '1, 1'b0, TAG_VOID, '0);
        add_req(OP_WRITE, 16, TAG_BOOL, '1);
        add_req(OP_READ, 16, 0, '0);
        // write types outside int..bool are refused
        add_fixed(OP_WRITE, 5, TAG_VOID, 64'hdead, 1'b0, TAG_VOID, '0);
        add_fixed(OP_WRITE, 5, TAG_ERROR, 64'hbeef, 1'b0, TAG_VOID, '0);
        add_req(OP_WRITE, 36, TAG_DOUBLE, 64'h8000_0000_0000_0001);
        add_req(OP_WRITE, 1, TAG_FLOAT, 64'h3f80_0000);
        add_req(OP_WRITE, 2, TAG_CHAR, 64'h41);
        add_req(OP_READ, 36, 0, '0);
        // new fill only takes effect at the next init
        add_reg(REG_FILL, 2);
        add_req(OP_READ, 20, 0, '0);
        add_fixed(OP_INIT, 0, 0, '0, 1'b1, TAG_VOID, '0);
        add_req(OP_READ, 1, 0, '0);
        add_req(OP_READ, 2, 0, '0);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                drain_requests();
                set_register(directed_rows[i].ridx, directed_rows[i].rval);
            end else begin
                send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].res);
            end
        end
        directed_count = req_count;

        // random phases, each with its own geometry and a leading init
        for (int ph = 0; ph < PHASES; ph++) begin
            calm = (ph == 4 || ph == 5);
            case (ph)
                0: load_geometry(NCHUNK, NSLOT, NSLOT, NSLOT, NSLOT, STORE_DEPTH);
                1: load_geometry(0, 0, 0, 0, 0, 0);
                3: load_geometry(7, 31, 31, 31, 31, 127);
                default: load_geometry(
                    ($urandom_range(0, 99) < 80) ? $urandom_range(1, NCHUNK) : $urandom_range(0, 7),
                    ($urandom_range(0, 99) < 75) ? $urandom_range(0, NSLOT) : $urandom_range(0, 31),
                    ($urandom_range(0, 99) < 75) ? $urandom_range(0, NSLOT) : $urandom_range(0, 31),
                    ($urandom_range(0, 99) < 75) ? $urandom_range(0, NSLOT) : $urandom_range(0, 31),
                    ($urandom_range(0, 99) < 75) ? $urandom_range(0, NSLOT) : $urandom_range(0, 31),
                    ($urandom_range(0, 99) < 75) ? $urandom_range(0, 40) : $urandom_range(0, 127));
            endcase
            send_request('{op: OP_INIT, idx: '0, wtype: '0, data: '0}, 1'b0, '0);
            for (int n = 1; n < REQS_PER_PHASE; n++) begin
                if (ph == 2 && n == 12) hold_now = 1'b1;
                send_request(random_request(), 1'b0, '0);
            end
        end

        drain_requests();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d directed, %0d inits), %0d results checked",
                 req_count, directed_count, init_count, result_count);
        $display("%0d register writes over %0d geometries, including clamped and empty ones",
                 reg_writes, PHASES + 3);
        if (mismatch_count == 0) begin
            $display("PASS chunked_typed_element_store");
        end else begin
            $display("FAIL chunked_typed_element_store");
        end
        $finish;
    end

endmodule

[files.f]
sv/ces_pkg.sv
sv/ces_store.sv
sv/ces_seq.sv
sv/ces_dp.sv
sv/chunked_typed_element_store.sv
tb/chunked_typed_element_store_test.sv
